/* rtl/shh_pkg.sv */
// Package for the sequence hash block: word and digit widths, start values,
// multiplier constants and the controller state type. No dependencies.
`default_nettype none

package shh_pkg;

  localparam int unsigned WordW   = 64;
  localparam int unsigned DigitW  = 4;
  localparam int unsigned NumDig  = WordW / DigitW;
  localparam int unsigned DigCntW = $clog2(NumDig);
  localparam int unsigned StepW   = 2;

  localparam logic [WordW-1:0] StartA = 64'hcbf29ce484222325;
  localparam logic [WordW-1:0] StartB = 64'h9e3779b97f4a7c15;
  localparam logic [WordW-1:0] MulA   = 64'h00000100000001b3;
  localparam logic [WordW-1:0] MulB   = 64'hff51afd7ed558ccd;

  localparam logic [StepW-1:0] StepALow  = 2'd0;
  localparam logic [StepW-1:0] StepAHigh = 2'd1;
  localparam logic [StepW-1:0] StepBHigh = 2'd2;
  localparam logic [StepW-1:0] StepBLow  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LAUNCH,
    ST_WAIT,
    ST_FLUSH
  } state_e;

endpackage

`default_nettype wire

/* rtl/shh_mul.sv */
// Digit-serial multiplier modulo 2^64 that consumes the coefficient one digit per cycle.
// Depends on shh_pkg for the word and digit widths.
`default_nettype none

module shh_mul (
  input  wire                     clk_i,
  input  wire                     rst_ni,
  input  wire                     start_i,
  input  wire [shh_pkg::WordW-1:0] op_i,
  input  wire [shh_pkg::WordW-1:0] coef_i,
  output logic                    done_o,
  output logic [shh_pkg::WordW-1:0] prod_o
);
  import shh_pkg::*;

  logic [WordW-1:0]   x_q, c_q, p_q;
  logic [DigCntW-1:0] cnt_q;
  logic               busy_q, done_q;
  logic [WordW-1:0]   part;

  // One digit of the coefficient times the shifted operand, truncated to the word.
  assign part = x_q * {{(WordW-DigitW){1'b0}}, c_q[DigitW-1:0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == DigCntW'(NumDig - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      x_q <= op_i;
      c_q <= coef_i;
      p_q <= '0;
    end else if (busy_q) begin
      p_q <= p_q + part;
      x_q <= x_q << DigitW;
      c_q <= c_q >> DigitW;
    end
  end

  assign done_o = done_q;
  assign prod_o = p_q;

endmodule

`default_nettype wire

/* rtl/sequence_hash_128.sv */
// Top level of the sequence hash block: stream ports, controller and accumulators.
// Depends on shh_pkg and shh_mul.
`default_nettype none

// Hashes a sequence of 128-bit identifiers into a 128-bit value with two
// multiply chains that share one digit-serial multiplier. Each identifier takes
// four dependent multiplies, the multiplier consuming four coefficient bits per
// cycle. A new identifier is accepted only once the previous one is folded in
// and, if it had tlast set, its hash is loaded into the output register. The result
// waits in that output register, and the next identifier is accepted while it waits.
module sequence_hash_128 (
  input  wire          clk_i,
  input  wire          rst_ni,
  input  wire          s_axis_tvalid,
  output logic         s_axis_tready,
  input  wire  [127:0] s_axis_tdata,   // id_low [63:0], id_high [127:64]
  input  wire          s_axis_tlast,   // last
  output logic         m_axis_tvalid,
  input  wire          m_axis_tready,
  output logic [127:0] m_axis_tdata    // hash_low [63:0], hash_high [127:64]
);
  import shh_pkg::*;

  state_e           state_q, state_d;
  logic [StepW-1:0] step_q, step_d;
  logic [WordW-1:0] acc_a_q, acc_a_d, acc_b_q, acc_b_d;
  logic [WordW-1:0] lo_q, hi_q;
  logic             last_q;
  logic             out_vld_q;
  logic [WordW-1:0] out_lo_q, out_hi_q;
  logic             load_in, load_out, slot_free;
  logic             mul_start, mul_done;
  logic [WordW-1:0] mul_op, mul_coef, mul_prod;

  shh_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .op_i   (mul_op),
    .coef_i (mul_coef),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  assign slot_free = !out_vld_q || m_axis_tready;

  always_comb begin
    case (step_q)
      StepALow:  mul_op = acc_a_q ^ lo_q;
      StepAHigh: mul_op = acc_a_q ^ hi_q;
      StepBHigh: mul_op = acc_b_q ^ hi_q;
      default:   mul_op = acc_b_q ^ lo_q;
    endcase
    mul_coef = (step_q == StepALow || step_q == StepAHigh) ? MulA : MulB;
  end

  always_comb begin
    state_d       = state_q;
    step_d        = step_q;
    acc_a_d       = acc_a_q;
    acc_b_d       = acc_b_q;
    s_axis_tready = 1'b0;
    load_in       = 1'b0;
    load_out      = 1'b0;
    mul_start     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          load_in = 1'b1;
          step_d  = StepALow;
          state_d = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        mul_start = 1'b1;
        state_d   = ST_WAIT;
      end
      ST_WAIT: begin
        if (mul_done) begin
          if (step_q == StepALow || step_q == StepAHigh) begin
            acc_a_d = mul_prod;
          end else begin
            acc_b_d = mul_prod;
          end
          if (step_q == StepBLow) begin
            state_d = last_q ? ST_FLUSH : ST_IDLE;
          end else begin
            step_d  = step_q + 1'b1;
            state_d = ST_LAUNCH;
          end
        end
      end
      ST_FLUSH: begin
        if (slot_free) begin
          load_out = 1'b1;
          acc_a_d  = StartA;
          acc_b_d  = StartB;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      step_q    <= StepALow;
      acc_a_q   <= StartA;
      acc_b_q   <= StartB;
      out_vld_q <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      acc_a_q <= acc_a_d;
      acc_b_q <= acc_b_d;
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_in) begin
      lo_q   <= s_axis_tdata[WordW-1:0];
      hi_q   <= s_axis_tdata[2*WordW-1:WordW];
      last_q <= s_axis_tlast;
    end
    if (load_out) begin
      out_lo_q <= acc_a_q;
      out_hi_q <= acc_b_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_hi_q, out_lo_q};

endmodule

`default_nettype wire

/* tb/sequence_hash_128_tb.sv */
// Self-checking testbench for sequence_hash_128: directed and random identifier
// sequences, with a software copy of the two multiply chains predicting each hash.
// Depends on shh_pkg and the sequence_hash_128 RTL.
`timescale 1ns / 1ps

module sequence_hash_128_tb;
  import shh_pkg::*;

  typedef struct {
    logic [63:0] low;
    logic [63:0] high;
  } hash_t;

  typedef struct {
    logic [63:0] id_low;
    logic [63:0] id_high;
    bit          last;
    bit          low_known;
    logic [63:0] low_val;
  } id_row_t;

  localparam int IdleLimit  = 5000;
  localparam int RandomIds  = 1750;
  localparam int NumRows    = 20;
  localparam logic [63:0] Ones = 64'hffffffffffffffff;

  // Each row is one identifier; low_known pins hash_low where it is obvious.
  id_row_t id_rows [NumRows] = '{
    '{64'h0, 64'h0, 1'b1, 1'b0, 64'h0},
    '{Ones, Ones, 1'b1, 1'b0, 64'h0},
    '{Ones, 64'h0, 1'b1, 1'b0, 64'h0},
    '{64'h0, Ones, 1'b1, 1'b0, 64'h0},
    '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b1, 1'b0, 64'h0},
    '{StartA, 64'h0, 1'b1, 1'b1, 64'h0},
    '{StartA, 64'h0, 1'b0, 1'b0, 64'h0},
    '{64'h0, 64'h0, 1'b1, 1'b1, 64'h0},
    '{64'h1, 64'h0, 1'b0, 1'b0, 64'h0},
    '{64'h0, 64'h1, 1'b0, 1'b0, 64'h0},
    '{64'h8000000000000000, 64'h8000000000000000, 1'b0, 1'b0, 64'h0},
    '{StartB, StartB, 1'b1, 1'b0, 64'h0},
    '{MulA, MulB, 1'b0, 1'b0, 64'h0},
    '{Ones, Ones, 1'b0, 1'b0, 64'h0},
    '{64'h0, 64'h0, 1'b0, 1'b0, 64'h0},
    '{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b1, 1'b0, 64'h0},
    '{64'h1, 64'h2, 1'b0, 1'b0, 64'h0},
    '{64'h2, 64'h1, 1'b1, 1'b0, 64'h0},
    '{64'h2, 64'h1, 1'b0, 1'b0, 64'h0},
    '{64'h1, 64'h2, 1'b1, 1'b0, 64'h0}
  };

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  logic [63:0] chain_a = StartA;
  logic [63:0] chain_b = StartB;
  hash_t       hash_due_q [$];
  int          fault_cnt = 0;
  int          idle_cycles = 0;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int          stall_left = 0;

  sequence_hash_128 dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [63:0] mix_word(input logic [63:0] acc, input logic [63:0] word,
                                           input logic [63:0] mul);
    logic [63:0] prod;
    prod = (acc ^ word) * mul;
    return prod;
  endfunction

  // Folds one accepted identifier into both chains and queues the hash on the last one.
  task automatic fold_id(input logic [63:0] id_low, input logic [63:0] id_high,
                         input bit last, input bit low_known, input logic [63:0] low_val);
    hash_t h;
    chain_a = mix_word(chain_a, id_low, MulA);
    chain_a = mix_word(chain_a, id_high, MulA);
    chain_b = mix_word(chain_b, id_high, MulB);
    chain_b = mix_word(chain_b, id_low, MulB);
    if (last) begin
      h.low  = low_known ? low_val : chain_a;
      h.high = chain_b;
      hash_due_q = {hash_due_q, h};
      chain_a = StartA;
      chain_b = StartB;
    end
  endtask

  task automatic send_id(input logic [63:0] id_low, input logic [63:0] id_high,
                         input bit last, input bit low_known, input logic [63:0] low_val);
    int gap;
    @(negedge clk_i);
    if ($urandom_range(99) < send_gap_pct) begin
      gap = ($urandom_range(4) == 0) ? $urandom_range(10, 100) : $urandom_range(1, 4);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {id_high, id_low};
    s_axis_tlast  = last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    fold_id(id_low, id_high, last, low_known, low_val);
  endtask

  function automatic logic [63:0] pick_word();
    logic [63:0] w;
    case ($urandom_range(9))
      0: w = 64'h0;
      1: w = Ones;
      2: w = 64'h1 << $urandom_range(63);
      3: w = ~(64'h1 << $urandom_range(63));
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  task automatic send_random_ids(input int count);
    int sent;
    int seq_len;
    sent = 0;
    while (sent < count) begin
      seq_len = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
      for (int k = 0; k < seq_len; k++) begin
        send_id(pick_word(), pick_word(), k == seq_len - 1, 1'b0, 64'h0);
      end
      sent += seq_len;
    end
  endtask

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      m_axis_tready = 1'b0;
      stall_left--;
    end else if ($urandom_range(99) < recv_stall_pct) begin
      m_axis_tready = 1'b0;
      stall_left = ($urandom_range(7) == 0) ? $urandom_range(20, 200) : $urandom_range(0, 2);
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (hash_due_q.size() == 0) begin
        $error("Unexpected hash transfer: %h", m_axis_tdata);
        fault_cnt++;
      end else begin
        if (m_axis_tdata[63:0] !== hash_due_q[0].low) begin
          $error("hash_low mismatch: expected %h, actual %h",
                 hash_due_q[0].low, m_axis_tdata[63:0]);
          fault_cnt++;
        end
        if (m_axis_tdata[127:64] !== hash_due_q[0].high) begin
          $error("hash_high mismatch: expected %h, actual %h",
                 hash_due_q[0].high, m_axis_tdata[127:64]);
          fault_cnt++;
        end
        void'(hash_due_q.pop_front());
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (rst_ni) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    for (int r = 0; r < NumRows; r++) begin
      send_id(id_rows[r].id_low, id_rows[r].id_high, id_rows[r].last,
              id_rows[r].low_known, id_rows[r].low_val);
    end

    // Four traffic phases: open flow, sender gaps, receiver stalls, then both.
    for (int ph = 0; ph < 4; ph++) begin
      send_gap_pct   = (ph == 1) ? 48 : (ph == 3) ? 24 : 0;
      recv_stall_pct = (ph == 2) ? 48 : (ph == 3) ? 24 : 0;
      send_random_ids(RandomIds / 4);
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;
    while (hash_due_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);

    if (fault_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/shh_pkg.sv
rtl/shh_mul.sv
rtl/sequence_hash_128.sv
tb/sequence_hash_128_tb.sv
